// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the keyed time-token hash RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/ttkh_pkg.sv -----
// Package for the keyed time-token hash: widths, register indexes, status type
// and the small byte/nibble helper functions. Depends on nothing.
package ttkh_pkg;

  localparam int BLK_W     = 64;
  localparam int TIME_W    = 24;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_SECRET   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_OUTPUT = 8'd1;

  localparam logic [7:0] ROUND_SUB = 8'd100;
  localparam logic [4:0] DEC_BASE  = 5'd10;
  localparam logic [4:0] FOLD_MOD  = 5'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } perm_sts_t;

  function automatic logic [BLK_W-1:0] bit_reverse(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    for (int i = 0; i < BLK_W; i++) r[i] = v[BLK_W-1-i];
    return r;
  endfunction

  function automatic logic [7:0] ror1(input logic [7:0] x);
    return {x[0], x[7:1]};
  endfunction

  // remainder by five for values below twenty
  function automatic logic [2:0] mod5(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'(3 * FOLD_MOD)) r = r - 5'(3 * FOLD_MOD);
    else if (r >= 5'(2 * FOLD_MOD)) r = r - 5'(2 * FOLD_MOD);
    else if (r >= FOLD_MOD) r = r - FOLD_MOD;
    return r[2:0];
  endfunction

  // nibble above nine folded into a decimal digit
  function automatic logic [3:0] fold_digit(input logic [3:0] d, input logic [2:0] c);
    logic [4:0] sub;
    logic [4:0] v;
    sub = {({1'b0, c} + 4'd1), 1'b0};
    v   = {1'b0, d} - sub;
    if (v >= DEC_BASE) v = v - DEC_BASE;
    return v[3:0];
  endfunction

endpackage

// ----- hdl/time_token_keyed_hash_top.sv -----
// Keyed time-token hash top level: stream ports, configuration registers,
// round and decimal-fold sequencer. Depends on ttkh_pkg, ttkh_perm, assert_macros.svh.
//
// One hash per input beat, one item at a time. An item passes through the
// first permutation, the four rounds, the second permutation and, when the
// decimal fold is enabled, the fold: each permutation makes one bit move per
// cycle in ttkh_perm, the four rounds step the block one bit at a time, and
// the decimal fold takes one byte per cycle. The finished hash sits in an
// output register, so the next time count is taken while the result waits.
`include "assert_macros.svh"
module time_token_keyed_hash_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ttkh_pkg::TIME_W-1:0]    in_tdata,   // [23:0] time_count
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ttkh_pkg::BLK_W-1:0]     out_tdata,  // [63:0] hash_block
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ttkh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ttkh_pkg::BLK_W-1:0]     cfg_data
);
  import ttkh_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PERM1 = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_PERM2 = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [BLK_W-1:0] secret_r, secret_nxt;
  logic             dec_r, dec_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [BLK_W-1:0] key_r, key_nxt;
  logic [7:0]       step_r, step_nxt;
  logic [2:0]       c_r, c_nxt;
  logic             pstart_r, pstart_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0] out_data_r, out_data_nxt;

  logic [BLK_W-1:0] perm_blk;
  perm_sts_t        perm_sts;

  logic [7:0]       b0, b4, s1, s2;
  logic             kbit;
  logic [BLK_W-1:0] mixed, rot;
  logic [7:0]       kb;
  logic [2:0]       c1, c2;
  logic [3:0]       hi, lo;

  ttkh_perm u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (pstart_r),
    .blk_in  (blk_r),
    .key_in  (key_r),
    .blk_out (perm_blk),
    .sts     (perm_sts)
  );

  // one round step: byte 0 / byte 4 mix then rotate the block left by one
  always_comb begin
    b0    = blk_r[63:56];
    b4    = blk_r[31:24];
    kbit  = key_r[~step_r[5:0]];
    mixed = blk_r;
    s1    = ror1(b0) - 8'd1;
    s2    = ror1(s1) - 8'd1;
    if (kbit ^ b0[7]) begin
      mixed[31:24] = ROUND_SUB - b0;
      mixed[63:56] = b4;
    end else begin
      mixed[63:56] = s2 ^ b4;
    end
    rot = {mixed[BLK_W-2:0], mixed[BLK_W-1]};
  end

  // one fold step on the top byte
  always_comb begin
    kb = key_r[63:56];
    c1 = mod5({2'b00, c_r} + {1'b0, kb[7:4]});
    c2 = mod5({2'b00, c1} + {1'b0, kb[3:0]});
    hi = (blk_r[63:60] > 4'd9) ? fold_digit(blk_r[63:60], c1) : blk_r[63:60];
    lo = (blk_r[59:56] > 4'd9) ? fold_digit(blk_r[59:56], c2) : blk_r[59:56];
  end

  always_comb begin
    state_nxt     = state_r;
    secret_nxt    = secret_r;
    dec_nxt       = dec_r;
    blk_nxt       = blk_r;
    key_nxt       = key_r;
    step_nxt      = step_r;
    c_nxt         = c_r;
    pstart_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid) begin
      if (cfg_index == REG_TOKEN_SECRET) secret_nxt = cfg_data;
      else if (cfg_index == REG_DECIMAL_OUTPUT) dec_nxt = cfg_data[0];
    end

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          blk_nxt = {in_tdata[23:16], in_tdata[15:8], in_tdata[7:0], in_tdata[7:0],
                     in_tdata[23:16], in_tdata[15:8], in_tdata[7:0], in_tdata[7:0]};
          key_nxt    = secret_r;
          pstart_nxt = 1'b1;
          state_nxt  = S_PERM1;
        end
      end
      S_PERM1: begin
        if (perm_sts.done) begin
          blk_nxt   = perm_blk;
          step_nxt  = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        blk_nxt  = rot;
        step_nxt = step_r + 8'd1;
        if (step_r[5:0] == 6'h3F) key_nxt = key_r ^ rot;
        if (step_r == 8'hFF) begin
          pstart_nxt = 1'b1;
          state_nxt  = S_PERM2;
        end
      end
      S_PERM2: begin
        if (perm_sts.done) begin
          blk_nxt = perm_blk;
          if (dec_r) begin
            c_nxt     = mod5({1'b0, key_r[3:0]});
            step_nxt  = '0;
            state_nxt = S_FOLD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FOLD: begin
        blk_nxt  = {blk_r[55:0], hi, lo};
        key_nxt  = {key_r[55:0], key_r[63:56]};
        c_nxt    = c2;
        step_nxt = step_r + 8'd1;
        if (step_r[2:0] == 3'd7) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = blk_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      secret_r    <= '0;
      dec_r       <= 1'b1;
      step_r      <= '0;
      c_r         <= '0;
      pstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      secret_r    <= secret_nxt;
      dec_r       <= dec_nxt;
      step_r      <= step_nxt;
      c_r         <= c_nxt;
      pstart_r    <= pstart_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blk_r      <= blk_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  `ASSERT_CLK(a_accept_starts_perm, clk, rst_n,
              (in_tvalid && in_tready) |=> pstart_r,
              "accepted beat did not start permutation")
  `ASSERT_CLK(a_perm_done_state, clk, rst_n,
              perm_sts.done |-> (state_r == S_PERM1 || state_r == S_PERM2),
              "permutation done outside a permutation phase")
  `ASSERT_CLK(a_rounds_end, clk, rst_n,
              (state_r == S_ROUND && step_r == 8'hFF) |=> (state_r == S_PERM2 && pstart_r),
              "rounds did not hand over to second permutation")
  `ASSERT_NEVER(a_start_when_idle, clk, rst_n, pstart_r && perm_sts.busy,
                "permutation started while busy")

endmodule

// ----- hdl/ttkh_perm.sv -----
// Key-driven 64-bit bit permutation, one move per cycle on a rotating register.
// Depends on ttkh_pkg and assert_macros.svh; used by time_token_keyed_hash_top.
`include "assert_macros.svh"
module ttkh_perm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ttkh_pkg::BLK_W-1:0] blk_in,
  input  logic [ttkh_pkg::BLK_W-1:0] key_in,
  output logic [ttkh_pkg::BLK_W-1:0] blk_out,
  output ttkh_pkg::perm_sts_t       sts
);
  import ttkh_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       s_r, s_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [BLK_W-1:0] w_r, w_nxt;
  logic [BLK_W-1:0] o_r, o_nxt;
  logic [BLK_W-1:0] key_r, key_nxt;
  logic [BLK_W-1:0] tmp;
  logic [3:0]       sn;
  logic [5:0]       p, d, pn;

  // w_r holds the work bits rotated so that the read pointer sits at bit 0
  always_comb begin
    sn  = s_r + 4'd1;
    p   = 6'd60 - {s_r, 2'b00};
    d   = 6'd0 - {s_r, 2'b00};
    pn  = 6'd60 - {sn, 2'b00};
    tmp = w_r;
    tmp[d] = w_r[0];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    s_nxt    = s_r;
    cnt_nxt  = cnt_r;
    w_nxt    = w_r;
    o_nxt    = o_r;
    key_nxt  = key_r;

    if (start) begin
      w_nxt    = bit_reverse(blk_in);
      key_nxt  = key_in;
      s_nxt    = '0;
      cnt_nxt  = key_in[BLK_W-1 -: 4];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != 4'd0) begin
        w_nxt   = {tmp[0], tmp[BLK_W-1:1]};
        cnt_nxt = cnt_r - 4'd1;
      end else begin
        o_nxt[p +: 4] = w_r[p +: 4];
        s_nxt   = sn;
        cnt_nxt = key_r[pn +: 4];
        if (s_r == 4'hF) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      s_r    <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      s_r    <= s_nxt;
      cnt_r  <= cnt_nxt;
    end
    w_r   <= w_nxt;
    o_r   <= o_nxt;
    key_r <= key_nxt;
  end

  assign blk_out  = bit_reverse(o_r);
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  `ASSERT_CLK(a_done_on_finish, clk, rst_n, $fell(busy_r) |-> done_r, "perm finished without done")
  `ASSERT_NEVER(a_no_restart, clk, rst_n, start && busy_r, "perm restarted while busy")
  `ASSERT_NEVER(a_done_not_busy, clk, rst_n, done_r && busy_r, "perm done while still busy")

endmodule

// ----- sim/time_token_keyed_hash_top_tb.sv -----
// Self-checking bench for time_token_keyed_hash_top: keyed hashes of time counts
// are predicted bit for bit and compared beat by beat. Needs ttkh_pkg and the RTL.
module time_token_keyed_hash_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttkh_pkg::*;

  localparam int QUIET_LIMIT       = 20000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int DRAIN_CYCLES      = 1000;
  localparam int ITEMS_PER_SETTING = 205;
  localparam int PRINT_LIMIT       = 40;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 8'd2;
  localparam logic [CFG_IDX_W-1:0] TOP_REG_IDX   = 8'hFF;

  typedef struct {
    logic [TIME_W-1:0] time_count;
    logic [BLK_W-1:0]  hash;
  } hash_expect_t;

  class token_hash_checker;
    logic [BLK_W-1:0] secret;
    bit               fold_en;
    hash_expect_t     expected_hashes[$];
    int               mismatch_count;
    int               hashes_noted;
    int               hashes_checked;

    function new();
      secret         = '0;
      fold_en        = 1'b1;
      mismatch_count = 0;
      hashes_noted   = 0;
      hashes_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BLK_W-1:0] val);
      if (idx == REG_TOKEN_SECRET) secret = val;
      else if (idx == REG_DECIMAL_OUTPUT) fold_en = val[0];
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction

    // bit position 0 is the msb of byte 0
    function logic [BLK_W-1:0] permute_bits(logic [BLK_W-1:0] blk, logic [BLK_W-1:0] key);
      bit [0:63] wrk;
      bit [0:63] outv;
      int        m, base, b, nib;
      wrk  = blk;
      outv = '0;
      m    = 0;
      for (int half = 0; half < 2; half++) begin
        base = (half != 0) ? 0 : 32;
        for (int k = 0; k < 8; k++) begin
          b   = 28 - 4 * k;
          nib = key[63 - 4 * (half * 8 + k) -: 4];
          for (int n = nib; n > 0; n--) begin
            wrk[(base + b + m + 4) & 63] = wrk[m];
            m = (m + 1) & 63;
          end
          for (int i = 0; i < 4; i++)
            outv[(base + b + i) & 63] |= wrk[(base + b + m + i) & 63];
        end
      end
      return outv;
    endfunction

    function logic [BLK_W-1:0] mix_rounds(input logic [BLK_W-1:0] blk,
                                          inout logic [BLK_W-1:0] key);
      logic [7:0] kb, b0, b4, s;
      for (int rd = 0; rd < 4; rd++) begin
        for (int i = 0; i < 8; i++) begin
          kb = key[63 - 8 * i -: 8];
          for (int j = 0; j < 8; j++) begin
            b0 = blk[63:56];
            b4 = blk[31:24];
            if (kb[7 - j] ^ b0[7]) begin
              blk[31:24] = ROUND_SUB - b0;
              blk[63:56] = b4;
            end else begin
              s = {b0[0], b0[7:1]} - 8'd1;
              s = {s[0], s[7:1]} - 8'd1;
              blk[63:56] = s ^ b4;
            end
            blk = {blk[62:0], blk[63]};
          end
        end
        key ^= blk;
      end
      return blk;
    endfunction

    function logic [BLK_W-1:0] fold_decimal(logic [BLK_W-1:0] blk, logic [BLK_W-1:0] key);
      int         c, hi, lo, base10, mod5;
      logic [7:0] kb;
      base10 = int'(DEC_BASE);
      mod5   = int'(FOLD_MOD);
      c      = int'(key[3:0]) % mod5;
      for (int i = 0; i < 8; i++) begin
        hi = int'(blk[63 - 8 * i -: 4]);
        lo = int'(blk[59 - 8 * i -: 4]);
        kb = key[63 - 8 * i -: 8];
        c  = (c + int'(kb[7:4])) % mod5;
        if (hi >= base10) hi = (hi - (c + 1) * 2) % base10;
        c  = (c + int'(kb[3:0])) % mod5;
        if (lo >= base10) lo = (lo - (c + 1) * 2) % base10;
        blk[63 - 8 * i -: 8] = {4'(hi), 4'(lo)};
      end
      return blk;
    endfunction

    function logic [BLK_W-1:0] predict_hash(logic [TIME_W-1:0] t);
      logic [BLK_W-1:0] blk, key;
      blk = {t[23:16], t[15:8], t[7:0], t[7:0], t[23:16], t[15:8], t[7:0], t[7:0]};
      key = secret;
      blk = permute_bits(blk, key);
      blk = mix_rounds(blk, key);
      blk = permute_bits(blk, key);
      if (fold_en) blk = fold_decimal(blk, key);
      return blk;
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task note_time(logic [TIME_W-1:0] t);
      hash_expect_t e;
      e.time_count = t;
      e.hash       = predict_hash(t);
      expected_hashes = {expected_hashes, e};
      hashes_noted++;
    endtask

    task check_hash(logic [BLK_W-1:0] got);
      hash_expect_t e;
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %h with no time count waiting", got));
      end else begin
        e = expected_hashes.pop_front();
        hashes_checked++;
        if (got !== e.hash)
          report_mismatch($sformatf("time %h: hash %h, expected %h", e.time_count, got, e.hash));
      end
    endtask
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TIME_W-1:0]    in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BLK_W-1:0]     out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BLK_W-1:0]     cfg_data   = '0;

  token_hash_checker book;
  int in_idle_pct  = 8;
  int out_idle_pct = 78;
  int settings_count = 0;
  int quiet_cycles = 0;

  time_token_keyed_hash_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) book.note_time(in_tdata);
      if (out_tvalid && out_tready) book.check_hash(out_tdata);
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d hashes outstanding",
                 QUIET_LIMIT, book.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_time(input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BLK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // fold flag goes in with random upper bits, which the block must ignore
  task automatic apply_setting(input logic [BLK_W-1:0] key, input bit fold);
    logic [BLK_W-1:0] flag_word;
    flag_word    = {$urandom, $urandom};
    flag_word[0] = fold;
    wait_idle();
    write_reg(REG_TOKEN_SECRET, key);
    write_reg(REG_DECIMAL_OUTPUT, flag_word);
    settings_count++;
  endtask

  initial begin
    logic [BLK_W-1:0]  key;
    bit                fold;
    logic [TIME_W-1:0] tc;
    book = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the registers
    send_time(24'h000000);
    send_time(24'hFFFFFF);
    send_time(24'h000001);

    // all-ones key, plain hex; writes to unmapped indexes must change nothing
    apply_setting({BLK_W{1'b1}}, 1'b0);
    write_reg(SPARE_REG_IDX, '0);
    write_reg(TOP_REG_IDX, {BLK_W{1'b1}});
    send_time(24'h000000);
    send_time(24'hFFFFFF);
    send_time(24'h800000);
    send_time(24'h7FFFFF);

    apply_setting(64'h0123_4567_89AB_CDEF, 1'b1);
    send_time(24'hAAAAAA);
    send_time(24'h555555);
    send_time(24'h000000);
    send_time(24'hFFFFFF);
    send_time(24'h123456);

    apply_setting(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
    send_time(24'h000080);
    send_time(24'h010000);
    send_time(24'hFF00FF);

    apply_setting(64'h8000_0000_0000_0001, 1'b1);
    send_time(24'h000000);
    send_time(24'hFFFFFF);
    send_time(24'h00FFFF);

    tc = 24'($urandom);
    for (int s = 0; s < 8; s++) begin
      if (s < 3) begin
        in_idle_pct  = 8;
        out_idle_pct = 78;
      end else if (s < 6) begin
        in_idle_pct  = 78;
        out_idle_pct = 8;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      key  = {$urandom, $urandom};
      fold = 1'b1;
      case (s)
        1: begin
          key  = {BLK_W{1'b1}};
          fold = 1'b0;
        end
        2, 7: fold = 1'b0;
        3: key = '0;
        4: key = key & 64'h3333_3333_3333_3333;
        5: fold = 1'($urandom_range(1));
        default: ;
      endcase
      apply_setting(key, fold);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (n == ITEMS_PER_SETTING / 2) wait_idle();
        // mostly random counts, some consecutive steps as a token would see
        tc = ($urandom_range(3) == 0) ? tc + 1'b1 : 24'($urandom);
        send_time(tc);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.pending() != 0)
      book.report_mismatch($sformatf("%0d hashes never arrived", book.pending()));

    $display("Hashed %0d time counts (%0d checked) under %0d key and fold settings,",
             book.hashes_noted, book.hashes_checked, settings_count);
    $display("with sender-side, receiver-side and no idling; %0d mismatches",
             book.mismatch_count);
    if (book.mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
